// ===== sv/totp_pkg.sv =====
// Package for the TOTP code generator: controller states, command and status
// structs, SHA-1 constants. No dependencies.
`default_nettype none
package totp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_MOD,
        ST_OUT
    } t_state;

    // Block selects for the shared compression unit
    typedef enum logic [1:0] {
        BLK_IPAD,
        BLK_MSG,
        BLK_OPAD,
        BLK_INNER
    } t_blk;

    typedef struct packed {
        logic start;      // capture input, begin division
        logic div_step;   // one division step (quotient, then remainder)
        logic load;       // load block into schedule, chain into working vars
        t_blk blk;
        logic init_h;     // reset chaining value to IV
        logic round;      // one SHA-1 round
        logic fold;       // add working vars into chaining value
        logic save_inner; // keep inner digest
        logic trunc;      // dynamic truncation
        logic mod_step;   // one step of mod 1000000
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rnd_done;
        logic mod_done;
    } t_sts;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [159:0] SHA_IV =
        160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [31:0] TZ_SCALE = 32'd3600;
    localparam logic [30:0] OTP_MOD = 31'd1000000;
    localparam logic [4:0] STEP_SECS = 5'd30;
    // Reciprocal of 30: quotient = (t * DIV30_MAGIC) >> DIV30_SHIFT for any 32-bit t
    localparam logic [31:0] DIV30_MAGIC = 32'h88888889;
    localparam int DIV30_SHIFT = 36;
    // Largest shift of OTP_MOD still below 2^31; the modulo walks down from it
    localparam logic [3:0] MOD_TOP_SHIFT = 4'd11;

endpackage
`default_nettype wire

// ===== sv/totp_hmac_sha1_code.sv =====
// TOTP code generator, top level: configuration registers, controller and
// datapath. Depends on totp_pkg, totp_ctrl and totp_dp.
//
// Use: present a clock reading on i_epoch_seconds with i_valid. The transfer
// completes at an edge with i_valid high and o_stall low. The block then
// takes the time-zone offset off, divides by 30 (reciprocal multiply, then
// remainder), runs four SHA-1 compressions on one shared round unit (each:
// load, 80 rounds, fold), and reduces the truncated window mod 1000000 in
// twelve subtract steps. One item is in flight at a time, and the next input
// is taken in the cycle after the output transfer.
// The result holds on o_otp_code and o_seconds_left with o_valid high until
// a transfer with i_stall low; o_stall stays high until then.
// Reset (synchronous, active low) clears the key to zero, sets the offset to
// one hour and returns the controller to idle. Configuration is to be written
// through i_cfg_we/i_cfg_index/i_cfg_data only while idle; the block itself
// does not enforce this.
`default_nettype none
module totp_hmac_sha1_code #(
    parameter int KEY_BYTES = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [19:0] o_otp_code,
    output logic [4:0]  o_seconds_left,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);
    import totp_pkg::*;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_TZ       = 2'd2;

    logic [15:0] r_key_high;
    logic [63:0] r_key_low;
    logic [4:0]  r_tz;

    // Hold configuration; writes beyond the register list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 16'd0;
            r_key_low  <= 64'd0;
            r_tz       <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_TZ:       r_tz       <= i_cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    t_cmd w_cmd;
    t_sts w_sts;

    totp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    totp_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_epoch_seconds (i_epoch_seconds),
        .i_key_high      (r_key_high),
        .i_key_low       (r_key_low),
        .i_tz            (r_tz),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_otp_code      (o_otp_code),
        .o_seconds_left  (o_seconds_left)
    );
endmodule
`default_nettype wire

// ===== sv/totp_ctrl.sv =====
// Controller for the TOTP code generator: sequences division, four SHA-1
// compressions, truncation and modulo. Depends on totp_pkg.
`default_nettype none
module totp_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  wire               i_stall,
    output totp_pkg::t_cmd    o_cmd,
    input  totp_pkg::t_sts    i_sts
);
    import totp_pkg::*;

    t_state r_state, n_state;
    t_blk   r_blk, n_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_blk   <= BLK_IPAD;
        end else begin
            r_state <= n_state;
            r_blk   <= n_blk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_DIV;
            ST_DIV:   if (i_sts.div_done) begin
                n_state = ST_LOAD;
                n_blk   = BLK_IPAD;
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (i_sts.rnd_done) n_state = ST_FOLD;
            ST_FOLD:  begin
                n_blk = t_blk'(r_blk + 2'd1);
                n_state = (r_blk == BLK_INNER) ? ST_MOD : ST_LOAD;
            end
            ST_MOD:   if (i_sts.mod_done) n_state = ST_OUT;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.blk = r_blk;
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
        case (r_state)
            ST_IDLE:  o_cmd.start = i_valid;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_LOAD:  begin
                o_cmd.load   = 1'b1;
                o_cmd.init_h = (r_blk == BLK_IPAD) || (r_blk == BLK_OPAD);
            end
            ST_ROUND: o_cmd.round = 1'b1;
            ST_FOLD:  begin
                o_cmd.fold       = 1'b1;
                o_cmd.save_inner = (r_blk == BLK_MSG);
                o_cmd.trunc      = (r_blk == BLK_INNER);
            end
            ST_MOD:   o_cmd.mod_step = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/totp_dp.sv =====
// Datapath for the TOTP code generator: time division by reciprocal
// multiplication, shared SHA-1 round unit, truncation and serial modulo.
// Depends on totp_pkg.
`default_nettype none
module totp_dp #(
    parameter int KEY_BYTES = 10
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire [31:0]         i_epoch_seconds,
    input  wire [15:0]         i_key_high,
    input  wire [63:0]         i_key_low,
    input  wire signed [4:0]   i_tz,
    input  totp_pkg::t_cmd     i_cmd,
    output totp_pkg::t_sts     o_sts,
    output logic [19:0]        o_otp_code,
    output logic [4:0]         o_seconds_left
);
    import totp_pkg::*;

    localparam int KB = (KEY_BYTES < 10) ? KEY_BYTES : 10;

    // Division by 30: quotient from the reciprocal product in the first
    // step, remainder from quotient * 30 in the second
    logic [31:0] r_adj;
    logic        r_dcnt;
    logic [31:0] r_counter;
    logic [63:0] w_prod;
    logic [31:0] w_qx30;
    logic [31:0] w_rem;
    logic signed [31:0] w_tzs;

    assign w_tzs  = 32'(i_tz) * $signed(TZ_SCALE);
    assign w_prod = 64'(r_adj) * 64'(DIV30_MAGIC);
    assign w_qx30 = {r_counter[26:0], 5'd0} - {r_counter[30:0], 1'b0};
    assign w_rem  = r_adj - w_qx30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= 1'b0;
        end else if (i_cmd.start) begin
            r_adj  <= i_epoch_seconds - 32'(w_tzs);
            r_dcnt <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_dcnt) begin
                r_counter <= {4'h0, w_prod[63:DIV30_SHIFT]};
            end else begin
                o_seconds_left <= STEP_SECS - w_rem[4:0];
            end
            r_dcnt <= ~r_dcnt;
        end
    end

    assign o_sts.div_done = i_cmd.div_step && r_dcnt;

    // Key bytes, masked to the used length
    logic [79:0] w_key;
    always_comb begin
        w_key = {i_key_high, i_key_low};
        for (int i = 0; i < 10; i++) begin
            if (i >= KB) w_key[79 - 8*i -: 8] = 8'h00;
        end
    end

    // Build the 512-bit block for the current compression
    logic [511:0] w_block;
    logic [159:0] r_inner;
    always_comb begin
        w_block = '0;
        case (i_cmd.blk)
            BLK_IPAD:  w_block = {w_key, 432'h0} ^ {64{IPAD_BYTE}};
            BLK_OPAD:  w_block = {w_key, 432'h0} ^ {64{OPAD_BYTE}};
            BLK_MSG:   w_block = {32'h0, r_counter, PAD_BYTE, 424'h0, 16'd576};
            BLK_INNER: w_block = {r_inner, PAD_BYTE, 328'h0, 16'd672};
            default:   w_block = '0;
        endcase
    end

    // Message schedule as a 16-word sliding window
    logic [31:0]  r_w [16];
    logic [159:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_rnd;
    logic [31:0]  w_f, w_k, w_t, w_wn, w_x;

    assign w_x  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_wn = {w_x[30:0], w_x[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = r_d ^ (r_b & (r_c ^ r_d)); w_k = K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d; w_k = K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_d & (r_b | r_c)); w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d; w_k = K3;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + w_k + r_e + r_w[0];
    end

    logic [159:0] w_hin;
    assign w_hin = i_cmd.init_h ? SHA_IV : r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd <= 7'd0;
        end else if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_w[i] <= w_block[511 - 32*i -: 32];
            {r_a, r_b, r_c, r_d, r_e} <= w_hin;
            r_h   <= w_hin;
            r_rnd <= 7'd0;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_wn;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
            r_rnd <= r_rnd + 7'd1;
        end else if (i_cmd.fold) begin
            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + r_d, r_h[31:0] + r_e};
        end
    end

    assign o_sts.rnd_done = i_cmd.round && (r_rnd == 7'd79);

    // Digest after fold, combinational view for truncation
    logic [159:0] w_dig;
    logic [3:0]   w_ofs;
    logic [31:0]  w_win;
    assign w_dig = {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + r_d, r_h[31:0] + r_e};
    assign w_ofs = w_dig[3:0];
    assign w_win = w_dig[159 - 8*w_ofs -: 32];

    // Mod 1000000 by shifting subtraction, 12 steps of OTP_MOD << 11 down to << 0
    logic [30:0] r_val;
    logic [3:0]  r_mcnt;
    logic [30:0] w_sub;
    assign w_sub = OTP_MOD << (MOD_TOP_SHIFT - r_mcnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= 4'd0;
        end else begin
            if (i_cmd.save_inner) r_inner <= w_dig;
            if (i_cmd.trunc) begin
                r_val  <= w_win[30:0];
                r_mcnt <= 4'd0;
            end else if (i_cmd.mod_step) begin
                if (r_val >= w_sub) r_val <= r_val - w_sub;
                r_mcnt <= r_mcnt + 4'd1;
            end
        end
    end

    assign o_sts.mod_done = i_cmd.mod_step && (r_mcnt == MOD_TOP_SHIFT);
    assign o_otp_code     = r_val[19:0];
endmodule
`default_nettype wire
